// ===== hw/rtl/binary_trie_longest_prefix_match_macros.svh =====
// Assertion macros for the trie match RTL, used by the back end.
// Depends on nothing; take it in with `include where assertions are written.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH

// Same-cycle implication, off while in reset.
`define BTLPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define BTLPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/btlpm_pkg.sv =====
// Types and codes of the binary trie longest-prefix match.
// Depends on nothing.
package btlpm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned HOP_W  = 8;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } btlpm_req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_HOP_HELD  = 2'd2
  } btlpm_status_t;

  // Classified request as it sits in the queue between front and back.
  typedef struct packed {
    logic              is_lookup;
    logic              zero_len;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  len;
    logic [HOP_W-1:0]  hop;
  } btlpm_item_t;

endpackage

// ===== hw/rtl/btlpm_if.sv =====
// Request and response channel interfaces (valid/ready).
// Depends on btlpm_pkg.
interface btlpm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [btlpm_pkg::ADDR_W-1:0]  address;
  logic [btlpm_pkg::LEN_W-1:0]   prefix_len;
  logic [btlpm_pkg::HOP_W-1:0]   next_hop_in;

  modport source (output valid, req_type, address, prefix_len, next_hop_in, input ready);
  modport sink   (input valid, req_type, address, prefix_len, next_hop_in, output ready);
endinterface

interface btlpm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [btlpm_pkg::HOP_W-1:0]   next_hop_out;
  logic                          hit;
  logic [1:0]                    status;

  modport source (output valid, next_hop_out, hit, status, input ready);
  modport sink   (input valid, next_hop_out, hit, status, output ready);
endinterface

// ===== hw/rtl/btlpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module btlpm_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/btlpm_front.sv =====
// Front end: takes request beats, classifies them and queues them (two entries).
// Depends on btlpm_pkg and btlpm_if.
module btlpm_front #(
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  btlpm_req_if.sink              req,
  output logic                   q_valid,
  input  logic                   q_ready,
  output btlpm_pkg::btlpm_item_t q_item
);
  localparam logic [btlpm_pkg::LEN_W-1:0] MAX_LEN = btlpm_pkg::LEN_W'(ADDRESS_BITS);

  btlpm_pkg::btlpm_item_t slots [2];
  btlpm_pkg::btlpm_item_t cls;
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  // Classify: saturate the length, flag zero length requests.
  always_comb begin
    cls.is_lookup = (req.req_type == btlpm_pkg::REQ_LOOKUP);
    cls.zero_len  = (req.prefix_len == '0);
    cls.address   = req.address;
    cls.len       = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;
    cls.hop       = req.next_hop_in;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/btlpm_back.sv =====
// Back end: walks the trie one level per cycle for inserts and lookups.
// Depends on btlpm_pkg, btlpm_if, btlpm_ram and the assertion macros header.
`include "binary_trie_longest_prefix_match_macros.svh"
module btlpm_back #(
  parameter int unsigned NODE_COUNT   = 4096,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  btlpm_pkg::btlpm_item_t q_item,
  btlpm_rsp_if.source            rsp
);
  localparam int unsigned IDXW  = $clog2(NODE_COUNT);
  localparam int unsigned LW    = $clog2(ADDRESS_BITS + 1);
  localparam int unsigned HW    = btlpm_pkg::HOP_W;
  localparam int unsigned WORDW = 2 * IDXW + 1 + HW;
  localparam logic [IDXW:0]  POOL_END = (IDXW + 1)'(NODE_COUNT);
  localparam logic [LW-1:0]  LAST_LVL = LW'(ADDRESS_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [IDXW-1:0] cur, cur_next;
  logic at_root, at_root_next, fresh, fresh_next;
  logic [LW-1:0] level, level_next;
  logic [ADDRESS_BITS-1:0] ab, ab_next;
  logic is_lookup, is_lookup_next;
  logic [btlpm_pkg::LEN_W-1:0] len, len_next;
  logic [HW-1:0] hop_in, hop_in_next;
  logic found, found_next;
  logic [HW-1:0] best, best_next;
  logic [IDXW:0] nodes_used, nodes_used_next;
  logic [IDXW-1:0] root_left, root_left_next, root_right, root_right_next;
  logic root_hv, root_hv_next;
  logic [HW-1:0] root_hop, root_hop_next;
  logic [HW-1:0] res_hop, res_hop_next;
  logic res_hit, res_hit_next;
  btlpm_pkg::btlpm_status_t res_status, res_status_next;

  logic [IDXW-1:0] v_left, v_right, w_left, w_right, child;
  logic v_hv, w_hv, do_write, ram_we, ram_re;
  logic [HW-1:0] v_hop, w_hop;
  logic [IDXW-1:0] ram_raddr;
  logic [WORDW-1:0] ram_rdata;

  // Node 0 lives in registers; the RAM holds nodes 1 and up.
  btlpm_ram #(.WIDTH(WORDW), .DEPTH(NODE_COUNT)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata ({w_left, w_right, w_hv, w_hop}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Current node: root registers, a fresh all-zero node, or the RAM read.
  always_comb begin
    if (at_root) begin
      {v_left, v_right, v_hv, v_hop} = {root_left, root_right, root_hv, root_hop};
    end else if (fresh) begin
      {v_left, v_right, v_hv, v_hop} = '0;
    end else begin
      {v_left, v_right, v_hv, v_hop} = ram_rdata;
    end
  end

  assign child = ab[ADDRESS_BITS-1] ? v_right : v_left;

  always_comb begin
    state_next = state;       cur_next = cur;         at_root_next = at_root;
    fresh_next = fresh;       level_next = level;     ab_next = ab;
    is_lookup_next = is_lookup; len_next = len;       hop_in_next = hop_in;
    found_next = found;       best_next = best;       nodes_used_next = nodes_used;
    res_hop_next = res_hop;   res_hit_next = res_hit; res_status_next = res_status;
    w_left = v_left; w_right = v_right; w_hv = v_hv; w_hop = v_hop;
    do_write = 1'b0; ram_re = 1'b0; ram_raddr = child;
    q_ready = 1'b0;
    case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_next = '0; at_root_next = 1'b1; fresh_next = 1'b0; level_next = '0;
          ab_next = q_item.address[ADDRESS_BITS-1:0];
          is_lookup_next = q_item.is_lookup; len_next = q_item.len;
          hop_in_next = q_item.hop; found_next = 1'b0; best_next = '0;
          if (!q_item.is_lookup && q_item.zero_len) begin
            res_hop_next = '0; res_hit_next = 1'b0; res_status_next = btlpm_pkg::ST_DONE;
            state_next = S_DONE;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (is_lookup) begin
          if (v_hv) begin
            found_next = 1'b1; best_next = v_hop;
          end
          if (level == LAST_LVL || child == '0) begin
            res_hop_next = v_hv ? v_hop : best;
            res_hit_next = found | v_hv;
            res_status_next = btlpm_pkg::ST_DONE;
            state_next = S_DONE;
          end else begin
            ram_re = 1'b1; cur_next = child; at_root_next = 1'b0;
            level_next = level + LW'(1); ab_next = ab << 1;
          end
        end else begin
          res_hop_next = '0; res_hit_next = 1'b0;
          if (btlpm_pkg::LEN_W'(level) == len) begin
            // Final node: first insert wins.
            if (v_hv) begin
              res_status_next = btlpm_pkg::ST_HOP_HELD;
            end else begin
              w_hv = 1'b1; w_hop = hop_in; do_write = 1'b1;
              res_status_next = btlpm_pkg::ST_DONE;
            end
            state_next = S_DONE;
          end else if (child != '0) begin
            ram_re = 1'b1; cur_next = child; at_root_next = 1'b0;
            level_next = level + LW'(1); ab_next = ab << 1;
          end else if (nodes_used == POOL_END) begin
            // Pool full: write out a fresh node so it reads as empty later.
            do_write = fresh;
            res_status_next = btlpm_pkg::ST_POOL_FULL;
            state_next = S_DONE;
          end else begin
            if (ab[ADDRESS_BITS-1]) w_right = nodes_used[IDXW-1:0];
            else                    w_left  = nodes_used[IDXW-1:0];
            do_write = 1'b1;
            cur_next = nodes_used[IDXW-1:0]; at_root_next = 1'b0; fresh_next = 1'b1;
            nodes_used_next = nodes_used + (IDXW + 1)'(1);
            level_next = level + LW'(1); ab_next = ab << 1;
          end
        end
      end
      S_DONE: begin
        if (rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign ram_we = do_write && !at_root;

  always_comb begin
    root_left_next = root_left; root_right_next = root_right;
    root_hv_next = root_hv;     root_hop_next = root_hop;
    if (do_write && at_root) begin
      root_left_next = w_left; root_right_next = w_right;
      root_hv_next = w_hv;     root_hop_next = w_hop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nodes_used <= (IDXW + 1)'(1);
      root_left <= '0; root_right <= '0; root_hv <= 1'b0;
    end else begin
      state <= state_next;
      nodes_used <= nodes_used_next;
      root_left <= root_left_next; root_right <= root_right_next; root_hv <= root_hv_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next; at_root <= at_root_next; fresh <= fresh_next;
    level <= level_next; ab <= ab_next; is_lookup <= is_lookup_next;
    len <= len_next; hop_in <= hop_in_next; found <= found_next; best <= best_next;
    root_hop <= root_hop_next;
    res_hop <= res_hop_next; res_hit <= res_hit_next; res_status <= res_status_next;
  end

  assign rsp.valid        = (state == S_DONE);
  assign rsp.next_hop_out = res_hop;
  assign rsp.hit          = res_hit;
  assign rsp.status       = res_status;

  `BTLPM_ASSERT_NOW(a_pool_bound, clk, rst, 1'b1, nodes_used <= POOL_END, "node pool overrun")
  `BTLPM_ASSERT_NOW(a_no_ram_root, clk, rst, ram_we, cur != '0, "RAM write aimed at root")
  `BTLPM_ASSERT_NOW(a_root_not_fresh, clk, rst, state == S_STEP && at_root, !fresh, "root marked fresh")
  `BTLPM_ASSERT_NEXT(a_done_to_idle, clk, rst, state == S_DONE && rsp.ready, state == S_IDLE, "beat not retired")
endmodule

// ===== hw/rtl/binary_trie_longest_prefix_match.sv =====
// IPv4 longest-prefix match over a binary trie: top level.
// Depends on btlpm_pkg, btlpm_if, btlpm_front, btlpm_back.
//
// Each request beat is either an insert (req_type 0) or a lookup (req_type 1).
// The front end takes request beats into a two-entry queue, so the request
// side keeps moving while the trie walker is busy. The walker handles one
// request at a time and spends one clock per trie level: it takes a beat from
// the queue, then visits the root and one node per address bit, each stored
// node below the root being fetched by a registered read of the node RAM. A
// lookup walks down to level ADDRESS_BITS at most and stops early at the first
// missing child; an insert walks down to the level of its length, capped at
// ADDRESS_BITS, or stops early when the pool runs out, and a zero length
// insert skips the walk. The response is then held until the response beat
// is taken, after which the walker returns to idle. The root node sits in
// flip-flops whose child pointers and hop-valid flag are cleared by reset,
// and every other node is written in full when an insert first steps onto
// it, so no RAM clearing pass is needed after reset. Status is 1 when the
// node pool is full (nodes allocated before that point stay) and 2 when the
// prefix already held a next hop, which is then kept.
module binary_trie_longest_prefix_match #(
  parameter int unsigned NODE_COUNT   = 4096,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  btlpm_req_if.sink    req,
  btlpm_rsp_if.source  rsp
);
  logic                   q_valid;
  logic                   q_ready;
  btlpm_pkg::btlpm_item_t q_item;

  // Accept and classify request beats.
  btlpm_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // Walk the trie and drive the response beat.
  btlpm_back #(.NODE_COUNT(NODE_COUNT), .ADDRESS_BITS(ADDRESS_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .rsp     (rsp)
  );
endmodule

// ===== tb/btlpm_checker.sv =====
// Watches the request and response channels of the trie match block, keeps its own trie
// and compares every response beat with the predicted one.
// Depends on btlpm_pkg and btlpm_if.
`timescale 1ns / 1ps

module btlpm_checker #(
  parameter int unsigned NODE_COUNT   = 4096,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  btlpm_req_if.sink   req_mon,
  btlpm_rsp_if.sink   rsp_mon,
  output int          fail_count,
  output int          pending,
  output int          lookups_seen,
  output int          hits_seen,
  output int          pool_full_seen
);

  typedef struct packed {
    logic [btlpm_pkg::HOP_W-1:0] hop;
    logic                        hit;
    btlpm_pkg::btlpm_status_t    status;
  } route_result_t;

  int unsigned   left_idx [NODE_COUNT];
  int unsigned   right_idx[NODE_COUNT];
  bit            has_hop  [NODE_COUNT];
  bit [btlpm_pkg::HOP_W-1:0] hop_val [NODE_COUNT];
  int unsigned   alloc_count;
  route_result_t awaited_routes[$];

  function automatic bit addr_bit(logic [btlpm_pkg::ADDR_W-1:0] a, int unsigned lvl);
    return a[ADDRESS_BITS - 1 - lvl];
  endfunction

  function automatic btlpm_pkg::btlpm_status_t add_route(logic [btlpm_pkg::ADDR_W-1:0] a,
                                                         int unsigned len,
                                                         logic [btlpm_pkg::HOP_W-1:0] h);
    int unsigned cur;
    int unsigned nxt;
    cur = 0;
    if (len > ADDRESS_BITS) len = ADDRESS_BITS;
    if (len == 0) return btlpm_pkg::ST_DONE;
    for (int unsigned i = 0; i < len; i++) begin
      nxt = addr_bit(a, i) ? right_idx[cur] : left_idx[cur];
      if (nxt == 0) begin
        if (alloc_count >= NODE_COUNT) return btlpm_pkg::ST_POOL_FULL;
        nxt = alloc_count;
        alloc_count++;
        left_idx[nxt] = 0;
        right_idx[nxt] = 0;
        has_hop[nxt] = 0;
        hop_val[nxt] = 0;
        if (addr_bit(a, i)) right_idx[cur] = nxt;
        else left_idx[cur] = nxt;
      end
      cur = nxt;
    end
    if (has_hop[cur]) return btlpm_pkg::ST_HOP_HELD;
    has_hop[cur] = 1;
    hop_val[cur] = h;
    return btlpm_pkg::ST_DONE;
  endfunction

  function automatic route_result_t match_route(logic [btlpm_pkg::ADDR_W-1:0] a);
    route_result_t r;
    int unsigned cur;
    r = '{hop: '0, hit: 1'b0, status: btlpm_pkg::ST_DONE};
    cur = 0;
    for (int unsigned d = 0; d <= ADDRESS_BITS; d++) begin
      if (has_hop[cur]) begin
        r.hit = 1'b1;
        r.hop = hop_val[cur];
      end
      if (d == ADDRESS_BITS) break;
      cur = addr_bit(a, d) ? right_idx[cur] : left_idx[cur];
      if (cur == 0) break;
    end
    return r;
  endfunction

  assign pending = awaited_routes.size();

  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        left_idx[i] = 0;
        right_idx[i] = 0;
        has_hop[i] = 0;
        hop_val[i] = 0;
      end
      alloc_count = 1;
      awaited_routes.delete();
      fail_count <= 0;
      lookups_seen <= 0;
      hits_seen <= 0;
      pool_full_seen <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_routes.size() == 0) begin
          $display("%0t: unexpected response beat hop=%0d hit=%0d status=%0d", $time,
                   rsp_mon.next_hop_out, rsp_mon.hit, rsp_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_routes.pop_front();
          if (rsp_mon.next_hop_out !== want.hop || rsp_mon.hit !== want.hit ||
              rsp_mon.status !== want.status) begin
            $display("%0t: mismatch expected hop=%0d hit=%0d status=%0d,", $time,
                     want.hop, want.hit, want.status);
            $display("  got hop=%0d hit=%0d status=%0d",
                     rsp_mon.next_hop_out, rsp_mon.hit, rsp_mon.status);
            fail_count <= fail_count + 1;
          end
          if (want.status == btlpm_pkg::ST_POOL_FULL) pool_full_seen <= pool_full_seen + 1;
          if (want.hit) hits_seen <= hits_seen + 1;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == btlpm_pkg::REQ_LOOKUP) begin
          awaited_routes.push_back(match_route(req_mon.address));
          lookups_seen <= lookups_seen + 1;
        end else begin
          want = '{hop: '0, hit: 1'b0,
                   status: add_route(req_mon.address, req_mon.prefix_len,
                                     req_mon.next_hop_in)};
          awaited_routes.push_back(want);
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the trie match testbench: drives request beats, stalls the response side and
// gives the verdict.
// Depends on btlpm_pkg, btlpm_if, btlpm_checker and the block itself.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NODES     = 4096;
  localparam int          RAND_ITEMS = 600;
  // Watchdog bound: room for the slowest walks, sender gaps and receiver stalls, plus slack.
  localparam int          CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count, pending, lookups_seen, hits_seen, pool_full_seen;
  bit   stim_done = 0;
  bit   hold_off = 0;

  btlpm_req_if req_ch();
  btlpm_rsp_if rsp_ch();

  binary_trie_longest_prefix_match #(.NODE_COUNT(NODES), .ADDRESS_BITS(32)) u_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  btlpm_checker #(.NODE_COUNT(NODES), .ADDRESS_BITS(32)) u_checker (
    .clk(clk), .rst(rst), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .fail_count(fail_count), .pending(pending), .lookups_seen(lookups_seen),
    .hits_seen(hits_seen), .pool_full_seen(pool_full_seen)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = btlpm_pkg::REQ_INSERT;
    req_ch.address = '0;
    req_ch.prefix_len = '0;
    req_ch.next_hop_in = '0;
    rsp_ch.ready = 1'b0;
  end

  // Put one request beat on the channel and hold it until accepted. An idle gap of
  // zero keeps valid high straight into the next beat.
  task automatic send_beat(btlpm_pkg::btlpm_req_t kind, logic [btlpm_pkg::ADDR_W-1:0] a,
                           logic [btlpm_pkg::LEN_W-1:0] len,
                           logic [btlpm_pkg::HOP_W-1:0] h, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.address <= a;
    req_ch.prefix_len <= len;
    req_ch.next_hop_in <= h;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Receiver: random stalls per beat, runs of no stall, and one long hold-off.
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Random address near a stem: one of four stems, with one random bit flipped half the time.
  function automatic logic [btlpm_pkg::ADDR_W-1:0] near_stem(
      logic [btlpm_pkg::ADDR_W-1:0] stems[4]);
    logic [btlpm_pkg::ADDR_W-1:0] a;
    a = stems[$urandom_range(0, 3)];
    if ($urandom_range(0, 1)) a ^= 32'(1) << $urandom_range(0, 31);
    return a;
  endfunction

  initial begin
    logic [btlpm_pkg::ADDR_W-1:0] stems[4];
    logic [btlpm_pkg::ADDR_W-1:0] a;
    int sel;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-table miss, zero length, default route, full-length routes,
    // first insert wins, overlong length, depth 32 lookups.
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'h1234_5678, 6'd0, 8'd9, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'h1234_5678, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'h0000_0000, 6'd32, 8'hFF, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h00, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h55, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'h0000_0001, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hC0A8_0000, 6'd16, 8'd7, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hC0A8_0100, 6'd24, 8'd8, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hC0A8_0101, 6'd63, 8'hAA, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hC0A8_0101, 6'd33, 8'hBB, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'hC0A8_0101, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'hC0A8_0102, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'hC0A8_0202, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'h8000_0000, 6'd1, 8'd1, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'h0000_0000, 6'd1, 8'd2, 1);
    send_beat(btlpm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0, 1);
    send_beat(btlpm_pkg::REQ_INSERT, 32'hDEAD_BEEF, 6'd0, 8'd3, 1);

    // Long receiver hold-off while requests keep coming back to back.
    hold_off = 1;
    for (int i = 0; i < 12; i++)
      send_beat(i[0] ? btlpm_pkg::REQ_LOOKUP : btlpm_pkg::REQ_INSERT, $urandom,
                6'($urandom_range(0, 32)), 8'($urandom), 0);

    for (int i = 0; i < 4; i++) stems[i] = $urandom;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 200 == 0) stems[$urandom_range(0, 3)] = $urandom;
      sel = $urandom_range(0, 9);
      a = (sel < 8) ? near_stem(stems) : 32'($urandom);
      if (sel < 4)
        send_beat(btlpm_pkg::REQ_INSERT, a, 6'($urandom_range(0, 63)), 8'($urandom),
                  i % 50 < 40);
      else
        send_beat(btlpm_pkg::REQ_LOOKUP, a, 6'($urandom), 8'($urandom), i % 50 < 40);
    end

    // Drain the pool with unrelated long prefixes so it runs full, probing it with lookups on the way.
    for (int i = 0; i < 180 && pool_full_seen < 8; i++) begin
      send_beat(btlpm_pkg::REQ_INSERT, $urandom, 6'd32, 8'($urandom), 1);
      if (i % 4 == 0)
        send_beat(btlpm_pkg::REQ_LOOKUP, near_stem(stems), 6'd0, 8'd0, 1);
    end
    req_ch.valid <= 1'b0;
    stim_done = 1;

    // Let the checker log the last accepted beat before polling what is outstanding.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("run covered %0d lookups (%0d hits) and the node pool running out %0d times",
             lookups_seen, hits_seen, pool_full_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
